@@ sv/hand_forward_kinematics_top_macros.svh @@
`ifndef HAND_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define HAND_FORWARD_KINEMATICS_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HFK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hfk assertion failed");

// next-cycle implication, checked outside reset
`define HFK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hfk assertion failed");

`endif

@@ sv/hfk_pkg.sv @@
package hfk_pkg;

    localparam int NUM_FINGERS   = 5;
    localparam int SEGMENTS      = 3;
    localparam int FRACTION_BITS = 24;
    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;

    localparam int OFF_ROOT    = 0;
    localparam int OFF_BASE    = OFF_ROOT + NUM_FINGERS * 3;
    localparam int OFF_LEN     = OFF_BASE + NUM_FINGERS * 9;
    localparam int OFF_LOW     = OFF_LEN + NUM_FINGERS * SEGMENTS;
    localparam int OFF_UP      = OFF_LOW + NUM_FINGERS * 4;
    localparam int OFF_ROT     = OFF_UP + NUM_FINGERS * 4;
    localparam int TABLE_DEPTH = OFF_ROT + 9;

    localparam int ADDR_W  = 7;
    localparam int ANG_W   = 28;
    localparam int ANGS_W  = 30;
    localparam int Z_W     = 38;
    localparam int XY_W    = 34;
    localparam int TRIG_W  = 33;
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int ACC_W   = 42;
    localparam int SAT_W   = 48;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 38'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 38'sd1686629713;
    localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 38'sd6746518852;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic                   is_write;
        logic [ADDR_W-1:0]      table_index;
        logic [31:0]            table_value;
        logic [2:0]             finger;
        logic [3:0][ANG_W-1:0]  ang;
        logic [2:0][31:0]       wrist;
    } t_item;

    typedef struct packed {
        logic [4:0]  point_index;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic        status;
        logic        last;
    } t_result;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-32:0] top;
        top = v[SAT_W-1:31];
        if ((&top) || !(|top)) begin
            return v[31:0];
        end
        return v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage

@@ sv/hfk_front.sv @@
module hfk_front (
    input  logic                    i_push,
    input  logic                    i_qfull,
    input  logic                    i_req_type,
    input  logic [6:0]              i_table_index,
    input  logic signed [31:0]      i_table_value,
    input  logic [2:0]              i_finger,
    input  logic signed [27:0]      i_abduction,
    input  logic signed [27:0]      i_flex_first,
    input  logic signed [27:0]      i_flex_second,
    input  logic signed [27:0]      i_flex_third,
    input  logic signed [31:0]      i_wrist_x,
    input  logic signed [31:0]      i_wrist_y,
    input  logic signed [31:0]      i_wrist_z,
    output logic                    o_qpush,
    output hfk_pkg::t_item          o_item
);
    import hfk_pkg::*;

    logic keep;

    // writes past the table and fingers past the hand are dropped here
    always_comb begin
        o_item.is_write    = !i_req_type;
        o_item.table_index = i_table_index;
        o_item.table_value = i_table_value;
        o_item.finger      = i_finger;
        o_item.ang         = {i_flex_third, i_flex_second, i_flex_first, i_abduction};
        o_item.wrist       = {i_wrist_z, i_wrist_y, i_wrist_x};
        if (!i_req_type) begin
            keep = ({1'b0, i_table_index} < 8'(TABLE_DEPTH));
        end else begin
            keep = ({1'b0, i_finger} < 4'(NUM_FINGERS));
        end
        o_qpush = i_push && !i_qfull && keep;
    end

endmodule

@@ sv/hfk_fifo.sv @@
module hfk_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

@@ sv/hfk_cordic.sv @@
module hfk_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [hfk_pkg::ANGS_W-1:0]    i_angle,
    output logic                                 o_done,
    output logic signed [hfk_pkg::TRIG_W-1:0]    o_sin,
    output logic signed [hfk_pkg::TRIG_W-1:0]    o_cos
);
    import hfk_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_RED  = 4'b0010,
        C_FOLD = 4'b0100,
        C_ROT  = 4'b1000
    } t_cstate;

    t_cstate                r_state;
    t_cstate                n_state;
    logic signed [Z_W-1:0]  r_z;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic [4:0]             r_i;
    logic                   r_flip;
    logic                   r_done;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic signed [Z_W-1:0]  atan_z;

    assign x_sh   = r_x >>> r_i;
    assign y_sh   = r_y >>> r_i;
    assign atan_z = {{(Z_W-32){1'b0}}, atan_q30(r_i)};
    assign o_done = r_done;
    assign o_sin  = TRIG_W'(r_flip ? -r_y : r_y);
    assign o_cos  = TRIG_W'(r_flip ? -r_x : r_x);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_RED;
            C_RED: begin
                if (r_z < TWO_PI_Q30 && r_z > -TWO_PI_Q30 &&
                    r_z <= PI_Q30 && r_z >= -PI_Q30) begin
                    n_state = C_FOLD;
                end
            end
            C_FOLD: n_state = C_ROT;
            C_ROT: if (r_i == 5'(CORDIC_ITERS - 1)) n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_ROT) && (r_i == 5'(CORDIC_ITERS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_z    <= Z_W'(i_angle) <<< (30 - FRACTION_BITS);
                    r_x    <= GAIN_Q30;
                    r_y    <= '0;
                    r_flip <= 1'b0;
                    r_i    <= '0;
                end
            end
            C_RED: begin
                // truncating remainder by two pi, then into [-pi, pi]
                if (r_z >= TWO_PI_Q30) begin
                    r_z <= r_z - TWO_PI_Q30;
                end else if (r_z <= -TWO_PI_Q30) begin
                    r_z <= r_z + TWO_PI_Q30;
                end else if (r_z > PI_Q30) begin
                    r_z <= r_z - TWO_PI_Q30;
                end else if (r_z < -PI_Q30) begin
                    r_z <= r_z + TWO_PI_Q30;
                end
            end
            C_FOLD: begin
                if (r_z > HALF_PI_Q30) begin
                    r_z    <= r_z - PI_Q30;
                    r_flip <= 1'b1;
                end else if (r_z < -HALF_PI_Q30) begin
                    r_z    <= r_z + PI_Q30;
                    r_flip <= 1'b1;
                end
            end
            C_ROT: begin
                if (!r_z[Z_W-1]) begin
                    r_x <= r_x - y_sh;
                    r_y <= r_y + x_sh;
                    r_z <= r_z - atan_z;
                end else begin
                    r_x <= r_x + y_sh;
                    r_y <= r_y - x_sh;
                    r_z <= r_z + atan_z;
                end
                r_i <= r_i + 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/hfk_back.sv @@
module hfk_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_qempty,
    input  hfk_pkg::t_item     i_item,
    output logic               o_qpop,
    input  logic               i_ofull,
    output logic               o_opush,
    output hfk_pkg::t_result   o_result
);
    import hfk_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LIM_A = 11'b000_0000_0010,
        S_LIM_B = 11'b000_0000_0100,
        S_LIM_C = 11'b000_0000_1000,
        S_ERR   = 11'b000_0001_0000,
        S_TRIG  = 11'b000_0010_0000,
        S_TWAIT = 11'b000_0100_0000,
        S_ADDR  = 11'b000_1000_0000,
        S_MUL   = 11'b001_0000_0000,
        S_ACC   = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        OP_V0,
        OP_V1,
        OP_D,
        OP_LEN,
        OP_ROOT,
        OP_Q
    } t_op;

    logic [31:0]               r_mem [TABLE_DEPTH];
    t_state                    r_state;
    t_state                    n_state;
    t_op                       r_op;
    t_item                     r_item;
    logic [1:0]                r_j;
    logic [2:0]                r_seg;
    logic [1:0]                r_i;
    logic [1:0]                r_k;
    logic signed [ANGS_W-1:0]  r_flex;
    logic signed [TRIG_W-1:0]  r_sa;
    logic signed [TRIG_W-1:0]  r_ca;
    logic signed [TRIG_W-1:0]  r_sf;
    logic signed [TRIG_W-1:0]  r_cf;
    logic signed [TRIG_W-1:0]  r_v [3];
    logic signed [31:0]        r_d;
    logic signed [31:0]        r_disp [3];
    logic signed [31:0]        r_p [3];
    logic signed [31:0]        r_out [3];
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [31:0]        r_rd;

    logic [ADDR_W-1:0]         rd_addr;
    logic                      rd_en;
    logic signed [ANG_W-1:0]   ang_j;
    logic signed [ANG_W-1:0]   ang_next;
    logic signed [TRIG_W-1:0]  mul_a;
    logic signed [TRIG_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]   prod_sh;
    logic signed [ACC_W-1:0]   acc_n;
    logic                      cs_start;
    logic signed [ANGS_W-1:0]  cs_angle;
    logic                      cs_done;
    logic signed [TRIG_W-1:0]  cs_sin;
    logic signed [TRIG_W-1:0]  cs_cos;
    logic                      is_last;

    hfk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cs_start),
        .i_angle (cs_angle),
        .o_done  (cs_done),
        .o_sin   (cs_sin),
        .o_cos   (cs_cos)
    );

    assign ang_j    = $signed(r_item.ang[r_j]);
    // a fourth segment adds no flexion
    assign ang_next = (r_seg < 3'd3) ? $signed(r_item.ang[2'(r_seg + 3'd1)]) : '0;
    assign cs_start = (r_state == S_TRIG);
    assign cs_angle = (r_seg == 3'd0) ? ANGS_W'(ang_j) : r_flex;
    assign is_last  = (r_seg == 3'(SEGMENTS));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            S_LIM_A: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(OFF_LOW + 4 * int'(r_item.finger) + int'(r_j));
            end
            S_LIM_B: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(OFF_UP + 4 * int'(r_item.finger) + int'(r_j));
            end
            S_ADDR: begin
                rd_en = 1'b1;
                case (r_op)
                    OP_D: rd_addr = ADDR_W'(OFF_BASE + 9 * int'(r_item.finger)
                                            + 3 * int'(r_i) + int'(r_k));
                    OP_LEN: rd_addr = ADDR_W'(OFF_LEN + SEGMENTS * int'(r_item.finger)
                                              + int'(r_seg) - 1);
                    OP_ROOT: rd_addr = ADDR_W'(OFF_ROOT + 3 * int'(r_item.finger)
                                               + int'(r_i));
                    OP_Q: rd_addr = ADDR_W'(OFF_ROT + 3 * int'(r_i) + int'(r_k));
                    default: rd_addr = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mul_a = TRIG_W'(r_rd);
        mul_b = '0;
        case (r_op)
            OP_V0: begin
                mul_a = r_sa;
                mul_b = r_cf;
            end
            OP_V1: begin
                mul_a = r_ca;
                mul_b = r_cf;
            end
            OP_D:   mul_b = r_v[r_k];
            OP_LEN: mul_b = TRIG_W'(r_d);
            OP_Q:   mul_b = TRIG_W'(r_p[r_k]);
            default: mul_b = '0;
        endcase
        if (r_op == OP_LEN || r_op == OP_Q) begin
            prod_sh = ACC_W'(r_prod >>> FRACTION_BITS);
        end else begin
            prod_sh = ACC_W'(r_prod >>> 30);
        end
        acc_n = r_acc + prod_sh;
    end

    always_comb begin
        o_qpop   = (r_state == S_IDLE) && !i_qempty;
        o_opush  = (r_state == S_ERR || r_state == S_EMIT) && !i_ofull;
        o_result.point_index = 5'(1 + int'(r_item.finger) * (SEGMENTS + 1) + int'(r_seg));
        o_result.point_x     = r_out[0];
        o_result.point_y     = r_out[1];
        o_result.point_z     = r_out[2];
        o_result.status      = 1'b0;
        o_result.last        = is_last;
        if (r_state == S_ERR) begin
            o_result.point_index = '0;
            o_result.point_x     = '0;
            o_result.point_y     = '0;
            o_result.point_z     = '0;
            o_result.status      = 1'b1;
            o_result.last        = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qempty && !i_item.is_write) n_state = S_LIM_A;
            end
            S_LIM_A: n_state = S_LIM_B;
            S_LIM_B: n_state = ($signed(32'(ang_j)) < r_rd) ? S_ERR : S_LIM_C;
            S_LIM_C: begin
                if ($signed(32'(ang_j)) > r_rd) begin
                    n_state = S_ERR;
                end else if (r_j == 2'd3) begin
                    n_state = S_TRIG;
                end else begin
                    n_state = S_LIM_A;
                end
            end
            S_ERR:   if (!i_ofull) n_state = S_IDLE;
            S_TRIG:  n_state = S_TWAIT;
            S_TWAIT: if (cs_done) n_state = S_ADDR;
            S_ADDR:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                if (r_op == OP_Q && r_k == 2'd2 && r_i == 2'd2) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_EMIT: begin
                if (!i_ofull) n_state = is_last ? S_IDLE : S_TRIG;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_qpop && i_item.is_write) begin
            r_mem[i_item.table_index] <= i_item.table_value;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_qpop) begin
                    r_item <= i_item;
                    r_j    <= '0;
                    r_seg  <= '0;
                end
            end
            S_LIM_C: begin
                r_j    <= r_j + 2'd1;
                r_flex <= '0;
            end
            S_TWAIT: begin
                if (cs_done) begin
                    if (r_seg == 3'd0) begin
                        r_sa <= cs_sin;
                        r_ca <= cs_cos;
                        r_disp[0] <= '0;
                        r_disp[1] <= '0;
                        r_disp[2] <= '0;
                        r_op <= OP_ROOT;
                        r_i  <= '0;
                    end else begin
                        r_sf <= cs_sin;
                        r_cf <= cs_cos;
                        r_op <= OP_V0;
                    end
                end
            end
            S_MUL: r_prod <= mul_a * mul_b;
            S_ACC: begin
                case (r_op)
                    OP_V0: begin
                        r_v[0] <= TRIG_W'(-prod_sh);
                        r_op   <= OP_V1;
                    end
                    OP_V1: begin
                        r_v[1] <= TRIG_W'(prod_sh);
                        r_v[2] <= r_sf;
                        r_op   <= OP_D;
                        r_i    <= '0;
                        r_k    <= '0;
                        r_acc  <= '0;
                    end
                    OP_D: begin
                        if (r_k == 2'd2) begin
                            r_d  <= sat32(SAT_W'(acc_n));
                            r_op <= OP_LEN;
                        end else begin
                            r_k   <= r_k + 2'd1;
                            r_acc <= acc_n;
                        end
                    end
                    OP_LEN: begin
                        r_disp[r_i] <= sat32(SAT_W'(r_disp[r_i]) + SAT_W'(prod_sh));
                        if (r_i == 2'd2) begin
                            r_i  <= '0;
                            r_op <= OP_ROOT;
                        end else begin
                            r_i   <= r_i + 2'd1;
                            r_k   <= '0;
                            r_acc <= '0;
                            r_op  <= OP_D;
                        end
                    end
                    OP_ROOT: begin
                        r_p[r_i] <= sat32(SAT_W'(r_rd) + SAT_W'(r_disp[r_i]));
                        if (r_i == 2'd2) begin
                            r_i   <= '0;
                            r_k   <= '0;
                            r_acc <= '0;
                            r_op  <= OP_Q;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                    OP_Q: begin
                        if (r_k == 2'd2) begin
                            r_out[r_i] <= sat32(SAT_W'(sat32(SAT_W'(acc_n)))
                                                + SAT_W'($signed(r_item.wrist[r_i])));
                            r_i   <= r_i + 2'd1;
                            r_k   <= '0;
                            r_acc <= '0;
                        end else begin
                            r_k   <= r_k + 2'd1;
                            r_acc <= acc_n;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EMIT: begin
                if (!i_ofull && !is_last) begin
                    r_seg  <= r_seg + 3'd1;
                    r_flex <= r_flex + ANGS_W'(ang_next);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/hand_forward_kinematics_top.sv @@
// table write: taken from the queue while idle, no result
// finger: one finger at a time; pace set by the shared cordic unit (wider angles take longer to
// reduce) and one multiplier stepping through 26 steps per segment (12 for the root point),
// each step passing through the address, multiply and accumulate states
// out-of-limit finger: one error result pushed once a limit check fails, no point results
// reset (synchronous, active low) empties both queues; table reads garbage until written
`include "hand_forward_kinematics_top_macros.svh"

module hand_forward_kinematics_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_req_type,
    input  logic [6:0]         i_table_index,
    input  logic signed [31:0] i_table_value,
    input  logic [2:0]         i_finger,
    input  logic signed [27:0] i_abduction,
    input  logic signed [27:0] i_flex_first,
    input  logic signed [27:0] i_flex_second,
    input  logic signed [27:0] i_flex_third,
    input  logic signed [31:0] i_wrist_x,
    input  logic signed [31:0] i_wrist_y,
    input  logic signed [31:0] i_wrist_z,
    output logic               empty,
    input  logic               pop,
    output logic [4:0]         o_point_index,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic               o_status,
    output logic               o_last
);
    import hfk_pkg::*;

    logic    item_push;
    t_item   item_in;
    t_item   item_out;
    logic    item_pop;
    logic    item_empty;
    logic    res_push;
    logic    res_full;
    t_result res_in;
    t_result res_out;

    hfk_front u_front (
        .i_push        (push),
        .i_qfull       (full),
        .i_req_type    (i_req_type),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_finger      (i_finger),
        .i_abduction   (i_abduction),
        .i_flex_first  (i_flex_first),
        .i_flex_second (i_flex_second),
        .i_flex_third  (i_flex_third),
        .i_wrist_x     (i_wrist_x),
        .i_wrist_y     (i_wrist_y),
        .i_wrist_z     (i_wrist_z),
        .o_qpush       (item_push),
        .o_item        (item_in)
    );

    hfk_fifo #(
        .W ($bits(t_item))
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  (item_in),
        .i_pop   (item_pop),
        .o_full  (full),
        .o_empty (item_empty),
        .o_data  (item_out)
    );

    hfk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qempty (item_empty),
        .i_item   (item_out),
        .o_qpop   (item_pop),
        .i_ofull  (res_full),
        .o_opush  (res_push),
        .o_result (res_in)
    );

    hfk_fifo #(
        .W ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_full  (res_full),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_point_index = res_out.point_index;
    assign o_point_x     = res_out.point_x;
    assign o_point_y     = res_out.point_y;
    assign o_point_z     = res_out.point_z;
    assign o_status      = res_out.status;
    assign o_last        = res_out.last;

    `HFK_ASSERT_NOW(a_err_is_last, (!empty && o_status), (o_last && o_point_index == 5'd0))
    `HFK_ASSERT_NOW(a_err_zero, (!empty && o_status), (o_point_x == 0 && o_point_y == 0 && o_point_z == 0))
    `HFK_ASSERT_NOW(a_res_no_overflow, res_push, !res_full)
    `HFK_ASSERT_NEXT(a_item_pop_frees, (item_pop && full && !item_push), !full)

endmodule
